// ===== hdl/dmps_pkg.sv =====
// shared types and constants for the dual motor pid speed block
package dmps_pkg;

  localparam int DATA_W         = 16;
  localparam int INTEGRAL_BITS  = 24;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int ERR_W          = DATA_W + 1;
  localparam int DIFF_W         = ERR_W + 1;
  localparam int GAIN_S_W       = DATA_W + 1;
  localparam int PP_W           = GAIN_S_W + ERR_W;
  localparam int PD_W           = GAIN_S_W + DIFF_W;
  localparam int PI_W           = GAIN_S_W + INTEGRAL_BITS;
  localparam int SUM_W          = PI_W + 1;
  localparam int CFG_IDX_W      = 3;

  localparam logic signed [INTEGRAL_BITS-1:0] INTEG_MAX =
    {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [INTEGRAL_BITS-1:0] INTEG_MIN =
    {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

  localparam logic [DATA_W-1:0] DRIVE_MAX_RST = '1;
  localparam logic [DATA_W-1:0] DRIVE_MIN_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_KP   = 3'd0,
    REG_LEFT_KI   = 3'd1,
    REG_LEFT_KD   = 3'd2,
    REG_RIGHT_KP  = 3'd3,
    REG_RIGHT_KI  = 3'd4,
    REG_RIGHT_KD  = 3'd5,
    REG_DRIVE_MAX = 3'd6,
    REG_DRIVE_MIN = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] kp;
    logic [DATA_W-1:0] ki;
    logic [DATA_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic [DATA_W-1:0] drive_max;
    logic [DATA_W-1:0] drive_min;
  } limits_t;

endpackage

// ===== hdl/dmps_if.sv =====
// request channels of the dual motor pid speed block

interface dmps_in_if;
  import dmps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] left_measured;
  logic signed [DATA_W-1:0] right_measured;
  logic signed [DATA_W-1:0] left_target;
  logic signed [DATA_W-1:0] right_target;

  modport source (output valid, left_measured, right_measured, left_target, right_target,
                  input ready);
  modport sink   (input valid, left_measured, right_measured, left_target, right_target,
                  output ready);
endinterface

interface dmps_out_if;
  import dmps_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] left_drive;
  logic [DATA_W-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

// ===== hdl/dmps_motor.sv =====
// one motor channel: error, saturating integral, gain products, shift and clamp
module dmps_motor (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load_a,
  input  dmps_pkg::gains_t                   gains,
  input  dmps_pkg::limits_t                  limits,
  input  logic signed [dmps_pkg::DATA_W-1:0] target,
  input  logic signed [dmps_pkg::DATA_W-1:0] measured,
  output logic        [dmps_pkg::DATA_W-1:0] drive
);
  import dmps_pkg::*;

  logic signed [ERR_W-1:0]         prev_err_r, prev_err_nxt;
  logic signed [INTEGRAL_BITS-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]         err;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [INTEGRAL_BITS:0]   isum;
  logic signed [INTEGRAL_BITS-1:0] isat;
  logic                            zero_tgt;
  logic signed [GAIN_S_W-1:0]      kp_s, ki_s, kd_s;

  logic signed [PP_W-1:0]          p_kp_r;
  logic signed [PD_W-1:0]          p_kd_r;
  logic signed [PI_W-1:0]          p_ki_r;
  logic                            zero_r;

  logic signed [SUM_W-1:0]         sum, shifted, hi_s, lo_s, v_hi, v_lo;

  // stage a: error and integral, state advances once per request
  assign err      = ERR_W'(target) - ERR_W'(measured);
  assign diff     = DIFF_W'(err) - DIFF_W'(prev_err_r);
  assign isum     = (INTEGRAL_BITS+1)'(integ_r) + (INTEGRAL_BITS+1)'(err);
  assign zero_tgt = (target == '0);
  assign kp_s     = {1'b0, gains.kp};
  assign ki_s     = {1'b0, gains.ki};
  assign kd_s     = {1'b0, gains.kd};

  always_comb begin
    if (isum[INTEGRAL_BITS] != isum[INTEGRAL_BITS-1]) begin
      isat = isum[INTEGRAL_BITS] ? INTEG_MIN : INTEG_MAX;
    end else begin
      isat = isum[INTEGRAL_BITS-1:0];
    end
    if (zero_tgt) begin
      prev_err_nxt = '0;
      integ_nxt    = '0;
    end else begin
      prev_err_nxt = err;
      integ_nxt    = isat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
    end else if (load_a) begin
      prev_err_r <= prev_err_nxt;
      integ_r    <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      p_kp_r <= kp_s * err;
      p_kd_r <= kd_s * diff;
      p_ki_r <= ki_s * isat;
      zero_r <= zero_tgt;
    end
  end

  // stage b: sum, floor shift, clamp high then low, zero drive for a zero target
  assign sum     = SUM_W'(p_kp_r) + SUM_W'(p_kd_r) + SUM_W'(p_ki_r);
  assign shifted = sum >>> GAIN_FRAC_BITS;
  assign hi_s    = SUM_W'({1'b0, limits.drive_max});
  assign lo_s    = SUM_W'({1'b0, limits.drive_min});
  assign v_hi    = (shifted > hi_s) ? hi_s : shifted;
  assign v_lo    = (v_hi < lo_s) ? lo_s : v_hi;
  assign drive   = zero_r ? '0 : v_lo[DATA_W-1:0];

endmodule

// ===== hdl/dual_motor_pid_speed.sv =====
// top level of the dual motor pid speed controller
// Takes one request per clock and returns one result per request, in order. A request
// goes through three registers (input, gain products, result) before its result is
// valid; a stalled output holds the pipeline, otherwise a new request enters every
// cycle. The integral and previous-error state of each motor updates as a request
// leaves the input register, so back-to-back requests see each other's state. The
// three 17 x 24-bit-or-narrower gain multiplies per motor set the register-to-register
// path. Gains and limits are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no request is in flight, as the block does not enforce it.
module dual_motor_pid_speed (
  input  logic                                  clk,
  input  logic                                  rst_n,
  dmps_in_if.sink                               in_chan,
  dmps_out_if.source                            out_chan,
  input  logic                                  cfg_we,
  input  logic [dmps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dmps_pkg::DATA_W-1:0]           cfg_data
);
  import dmps_pkg::*;

  gains_t  left_gains_r, right_gains_r;
  limits_t limits_r;

  logic                     v0_r, v1_r, v2_r;
  logic                     rdy0, rdy1, rdy2;
  logic                     mv0, mv1;
  logic signed [DATA_W-1:0] lm_r, rm_r, lt_r, rt_r;
  logic        [DATA_W-1:0] left_drive, right_drive;
  logic        [DATA_W-1:0] left_drive_r, right_drive_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_gains_r       <= '0;
      right_gains_r      <= '0;
      limits_r.drive_max <= DRIVE_MAX_RST;
      limits_r.drive_min <= DRIVE_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_KP:   left_gains_r.kp    <= cfg_data;
        REG_LEFT_KI:   left_gains_r.ki    <= cfg_data;
        REG_LEFT_KD:   left_gains_r.kd    <= cfg_data;
        REG_RIGHT_KP:  right_gains_r.kp   <= cfg_data;
        REG_RIGHT_KI:  right_gains_r.ki   <= cfg_data;
        REG_RIGHT_KD:  right_gains_r.kd   <= cfg_data;
        REG_DRIVE_MAX: limits_r.drive_max <= cfg_data;
        REG_DRIVE_MIN: limits_r.drive_min <= cfg_data;
        default:       ;
      endcase
    end
  end

  // pipeline flow control
  assign rdy2 = !v2_r || out_chan.ready;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign mv1  = v1_r && rdy2;
  assign mv0  = v0_r && rdy1;

  assign in_chan.ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_chan.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && rdy0) begin
      lm_r <= in_chan.left_measured;
      rm_r <= in_chan.right_measured;
      lt_r <= in_chan.left_target;
      rt_r <= in_chan.right_target;
    end
    if (mv1) begin
      left_drive_r  <= left_drive;
      right_drive_r <= right_drive;
    end
  end

  dmps_motor u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_a   (mv0),
    .gains    (left_gains_r),
    .limits   (limits_r),
    .target   (lt_r),
    .measured (lm_r),
    .drive    (left_drive)
  );

  dmps_motor u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_a   (mv0),
    .gains    (right_gains_r),
    .limits   (limits_r),
    .target   (rt_r),
    .measured (rm_r),
    .drive    (right_drive)
  );

  assign out_chan.valid       = v2_r;
  assign out_chan.left_drive  = left_drive_r;
  assign out_chan.right_drive = right_drive_r;

endmodule

// ===== test/tb_dual_motor_pid_speed.sv =====
// self-checking testbench for dual_motor_pid_speed: directed and random ticks against an in-bench pid model
module tb_dual_motor_pid_speed;
  import dmps_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int STALL_CYCLES = 400;
  localparam logic signed [DATA_W-1:0] SPEED_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SPEED_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_measured;
    logic signed [DATA_W-1:0] right_measured;
    logic signed [DATA_W-1:0] left_target;
    logic signed [DATA_W-1:0] right_target;
  } tick_t;

  typedef struct packed {
    logic [DATA_W-1:0] left_drive;
    logic [DATA_W-1:0] right_drive;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  dmps_in_if  in_if ();
  dmps_out_if out_if ();

  dual_motor_pid_speed i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // model copy of the registers and the per-motor loop state
  logic [DATA_W-1:0] loop_regs [8] = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                                       DRIVE_MAX_RST, DRIVE_MIN_RST};
  logic signed [ERR_W-1:0] prev_err [2] = '{'0, '0};
  logic signed [INTEGRAL_BITS-1:0] err_sum [2] = '{'0, '0};

  tick_t pending_ticks [$];
  drive_t expected_drives [$];

  int fail_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_asked = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic logic [DATA_W-1:0] pid_drive(input int m,
      input logic signed [DATA_W-1:0] target, measured,
      input logic [DATA_W-1:0] kp, ki, kd);
    longint err, acc, sum, v;
    if (target == 0) begin
      prev_err[m] = '0;
      err_sum[m] = '0;
      return '0;
    end
    err = longint'(target) - longint'(measured);
    acc = longint'(err_sum[m]) + err;
    if (acc > longint'(INTEG_MAX)) acc = longint'(INTEG_MAX);
    if (acc < longint'(INTEG_MIN)) acc = longint'(INTEG_MIN);
    sum = longint'(kp) * err + longint'(kd) * (err - longint'(prev_err[m]))
        + longint'(ki) * acc;
    prev_err[m] = err[ERR_W-1:0];
    err_sum[m] = acc[INTEGRAL_BITS-1:0];
    // arithmetic shift floors negative sums
    v = sum >>> GAIN_FRAC_BITS;
    if (v > longint'(loop_regs[REG_DRIVE_MAX])) v = longint'(loop_regs[REG_DRIVE_MAX]);
    if (v < longint'(loop_regs[REG_DRIVE_MIN])) v = longint'(loop_regs[REG_DRIVE_MIN]);
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_target();
    logic signed [DATA_W-1:0] v;
    if ($urandom_range(3) == 0) begin
      v = DATA_W'($urandom);
      if (v == 0) v = 1;
    end else begin
      v = DATA_W'($urandom_range(2000, 1));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] speed_noise();
    return DATA_W'(int'($urandom_range(600)) - 300);
  endfunction

  task automatic program_loop(input logic [DATA_W-1:0] lkp, lki, lkd, rkp, rki, rkd,
                              dmax, dmin);
    logic [DATA_W-1:0] vals [8];
    vals = '{lkp, lki, lkd, rkp, rki, rkd, dmax, dmin};
    for (int r = 0; r < 8; r++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= vals[r];
      loop_regs[r] = vals[r];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    tick_t t;
    int kind, len;
    logic signed [DATA_W-1:0] lt, rt;
    while (count > 0) begin
      kind = $urandom_range(9);
      len = (kind == 0) ? $urandom_range(160, 60) : $urandom_range(30, 4);
      lt = pick_target();
      rt = pick_target();
      for (int i = 0; i < len && count > 0; i++) begin
        case (kind)
          0: begin
            // largest error of one sign, in runs that can be long enough to saturate the integral
            t.left_target = lt[DATA_W-1] ? SPEED_MIN : SPEED_MAX;
            t.right_target = rt[DATA_W-1] ? SPEED_MIN : SPEED_MAX;
            t.left_measured = ~t.left_target ^ DATA_W'($urandom_range(255));
            t.right_measured = ~t.right_target ^ DATA_W'($urandom_range(255));
          end
          7, 8: begin
            t = tick_t'({$urandom, $urandom});
            if ($urandom_range(99) < 6) t.left_target = '0;
            if ($urandom_range(99) < 6) t.right_target = '0;
          end
          9: begin
            t = tick_t'({$urandom, $urandom});
            t.left_target = '0;
            t.right_target = '0;
          end
          default: begin
            // tracking: measured speed hovers around a fixed target
            t.left_target = ($urandom_range(99) < 3) ? '0 : lt;
            t.right_target = ($urandom_range(99) < 3) ? '0 : rt;
            t.left_measured = lt + speed_noise();
            t.right_measured = rt + speed_noise();
          end
        endcase
        pending_ticks.push_back(t);
        count--;
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_t t;
        t = pending_ticks.pop_front();
        in_if.valid <= 1'b1;
        in_if.left_measured <= t.left_measured;
        in_if.right_measured <= t.right_measured;
        in_if.left_target <= t.left_target;
        in_if.right_target <= t.right_target;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (stall_seen != stall_asked) begin
        stall_seen = stall_asked;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // results are checked before the same edge's request is predicted
  always @(posedge clk) begin : pid_check
    drive_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_drives.size() == 0) begin
          fail_cnt++;
          $error("left_drive/right_drive: no result expected, got %0d/%0d",
                 out_if.left_drive, out_if.right_drive);
        end else begin
          want = expected_drives.pop_front();
          if (out_if.left_drive !== want.left_drive) begin
            fail_cnt++;
            $error("left_drive: expected %0d, got %0d", want.left_drive, out_if.left_drive);
          end
          if (out_if.right_drive !== want.right_drive) begin
            fail_cnt++;
            $error("right_drive: expected %0d, got %0d", want.right_drive,
                   out_if.right_drive);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        want.left_drive = pid_drive(0, in_if.left_target, in_if.left_measured,
                                    loop_regs[REG_LEFT_KP], loop_regs[REG_LEFT_KI],
                                    loop_regs[REG_LEFT_KD]);
        want.right_drive = pid_drive(1, in_if.right_target, in_if.right_measured,
                                     loop_regs[REG_RIGHT_KP], loop_regs[REG_RIGHT_KI],
                                     loop_regs[REG_RIGHT_KD]);
        expected_drives.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL dual_motor_pid_speed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tick_t directed [15];
    directed = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{SPEED_MIN, SPEED_MAX, SPEED_MAX, SPEED_MIN},
      '{SPEED_MIN, SPEED_MAX, SPEED_MAX, SPEED_MIN},
      '{SPEED_MAX, SPEED_MIN, SPEED_MAX, SPEED_MIN},
      '{16'sd200, 16'sd200, 16'sd100, -16'sd100},
      '{-16'sd1, 16'sd1, 16'sd1, -16'sd1},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd100, -16'sd100, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, SPEED_MAX, SPEED_MAX},
      '{SPEED_MIN, SPEED_MIN, SPEED_MIN, SPEED_MIN},
      '{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555},
      '{16'sd1000, -16'sd1000, 16'sd1500, -16'sd1500},
      '{16'sd1200, -16'sd1300, 16'sd1500, -16'sd1500},
      '{16'sd500, 16'sd500, 16'sd0, 16'sd700},
      '{16'sd500, 16'sd500, 16'sd700, 16'sd0}
    };
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 81;
    program_loop(16'h0100, 16'h0008, 16'h0040, 16'h0100, 16'h0008, 16'h0040,
                 16'hffff, 16'h0000);
    foreach (directed[i]) pending_ticks.push_back(directed[i]);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin send_idle_pct = 14; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: program_loop(16'h0100, 16'h0008, 16'h0040, 16'h0100, 16'h0008, 16'h0040,
                        16'hffff, 16'h0000);
        1: program_loop(16'h0040, 16'h0002, 16'h0020, 16'h0200, 16'h0010, 16'h0080,
                        16'd4000, 16'd200);
        2: program_loop(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff, 16'h0000);
        3: program_loop(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                        DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                        DATA_W'($urandom), DATA_W'($urandom));
        4: program_loop(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'd1234, 16'd567);
        // min above max: every running motor ends up at the lower limit
        5: program_loop(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                        DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                        16'h0000, 16'hffff);
        6: program_loop(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                        16'hffff, 16'h0000);
        7: program_loop(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                        DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                        16'hffff, 16'h0000);
        default: program_loop(16'h8000, 16'h0100, 16'hffff, 16'h0080, 16'h0004, 16'h0200,
                              16'h7fff, 16'h0001);
      endcase
      queue_random(150);
      // back-pressure while the sender keeps offering requests
      if (p == 7) stall_asked++;
      wait_drained();
    end

    if (fail_cnt == 0 && expected_drives.size() == 0) begin
      $display("PASS dual_motor_pid_speed");
    end else begin
      $display("FAIL dual_motor_pid_speed");
    end
    $finish;
  end

endmodule
